### sv/prb_pkg.sv
// Shared constants and types for the point rotation block.
// Angle formats, inverse gain and the arctangent table of the rotator stages.
// No dependencies.
package prb_pkg;

  localparam int ANG_WIDTH    = 17;
  localparam int FULL_TURN    = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;
  localparam int ANG_SHIFT    = 9;
  localparam int GUARD_BITS   = 30;
  localparam int EXT_BITS     = 32;
  localparam int Z_WIDTH      = 27;
  localparam int ATAN_DEPTH   = 32;

  localparam logic [GUARD_BITS-1:0] INV_GAIN_Q30 = 30'h26DD3B6A;

  typedef logic signed [ANG_WIDTH-1:0] angle_t;
  typedef logic signed [Z_WIDTH-1:0]   z_t;

  localparam z_t ATAN_TBL [ATAN_DEPTH] = '{
    z_t'(2949120), z_t'(1740967), z_t'(919879), z_t'(466945),
    z_t'(234379),  z_t'(117304),  z_t'(58666),  z_t'(29335),
    z_t'(14668),   z_t'(7334),    z_t'(3667),   z_t'(1833),
    z_t'(917),     z_t'(458),     z_t'(229),    z_t'(115),
    z_t'(57),      z_t'(29),      z_t'(14),     z_t'(7),
    z_t'(4),       z_t'(2),       z_t'(1),      z_t'(0),
    z_t'(0),       z_t'(0),       z_t'(0),      z_t'(0),
    z_t'(0),       z_t'(0),       z_t'(0),      z_t'(0)
  };

endpackage

### sv/prb_if.sv
// Valid/ready channel interfaces for points in and rotated points out.
// Depends on prb_pkg.
interface prb_in_if #(parameter int CW = 16);
  logic                               valid;
  logic                               ready;
  logic signed [CW-1:0]               x_in;
  logic signed [CW-1:0]               y_in;
  logic signed [prb_pkg::ANG_WIDTH-1:0] angle_deg;

  modport source (output valid, x_in, y_in, angle_deg, input ready);
  modport sink   (input valid, x_in, y_in, angle_deg, output ready);
endinterface

interface prb_out_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x_out;
  logic signed [CW-1:0] y_out;
  logic                 saturated;

  modport source (output valid, x_out, y_out, saturated, input ready);
  modport sink   (input valid, x_out, y_out, saturated, output ready);
endinterface

### sv/point_rotation_by_degrees_top.sv
// Clockwise rotation of a Q8.8 point by a Q9.7 angle in degrees, pipelined rotator.
// Pipeline of ITERATIONS + 4 register stages. Accepts one point per cycle while the
// output is not held off; every stage register advances independently, so bubbles
// close up under output back-pressure.
// Reset clears the stage valid bits only; the data registers are not reset.
// Depends on prb_pkg, prb_if, prb_prep, prb_iter and prb_out.
module point_rotation_by_degrees_top #(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  prb_in_if.sink    in_ch,
  prb_out_if.source out_ch
);
  import prb_pkg::*;

  localparam int W = COORD_WIDTH + EXT_BITS;

  logic                cv   [ITERATIONS+1];
  logic                crdy [ITERATIONS+1];
  logic signed [W-1:0] cx   [ITERATIONS+1];
  logic signed [W-1:0] cy   [ITERATIONS+1];
  z_t                  cz   [ITERATIONS+1];

  prb_prep #(.CW(COORD_WIDTH)) u_prep (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (in_ch.valid),
    .rdy_o (in_ch.ready),
    .x_i   (in_ch.x_in),
    .y_i   (in_ch.y_in),
    .a_i   (in_ch.angle_deg),
    .v_o   (cv[0]),
    .rdy_i (crdy[0]),
    .x_o   (cx[0]),
    .y_o   (cy[0]),
    .z_o   (cz[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    prb_iter #(.CW(COORD_WIDTH), .IDX(i)) u_iter (
      .clk   (clk),
      .rst_n (rst_n),
      .v_i   (cv[i]),
      .rdy_o (crdy[i]),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .v_o   (cv[i+1]),
      .rdy_i (crdy[i+1]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  prb_out #(.CW(COORD_WIDTH)) u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .v_i   (cv[ITERATIONS]),
    .rdy_o (crdy[ITERATIONS]),
    .x_i   (cx[ITERATIONS]),
    .y_i   (cy[ITERATIONS]),
    .v_o   (out_ch.valid),
    .rdy_i (out_ch.ready),
    .x_o   (out_ch.x_out),
    .y_o   (out_ch.y_out),
    .sat_o (out_ch.saturated)
  );

  // input only stalls when every stage is full and the sink holds off
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled without output back-pressure");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid straight after reset");

  // a residual angle left at the end of the rotator is small
  a_residual: assert property (@(posedge clk) disable iff (!rst_n)
    cv[ITERATIONS] |-> (cz[ITERATIONS] < z_t'(1 << 22) && cz[ITERATIONS] > -z_t'(1 << 22)))
    else $error("rotator residual angle out of range");

endmodule

### sv/prb_prep.sv
// Front end: angle reduction, half-turn fold and scaling by the inverse gain.
// Three register stages. Depends on prb_pkg.
module prb_prep #(
  parameter int CW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          v_i,
  output logic                          rdy_o,
  input  logic signed [CW-1:0]          x_i,
  input  logic signed [CW-1:0]          y_i,
  input  prb_pkg::angle_t               a_i,
  output logic                          v_o,
  input  logic                          rdy_i,
  output logic signed [CW+prb_pkg::EXT_BITS-1:0] x_o,
  output logic signed [CW+prb_pkg::EXT_BITS-1:0] y_o,
  output prb_pkg::z_t                   z_o
);
  import prb_pkg::*;

  localparam int W = CW + EXT_BITS;

  logic v0_r, v1_r, v2_r;
  logic rdy0, rdy1, rdy2;

  // stage 0: angle modulo a full turn
  logic signed [ANG_WIDTH:0] a18, m1, m2;
  logic [ANG_WIDTH-2:0]      m_r;
  logic signed [CW-1:0]      x0_r, y0_r;

  // stage 1: fold to +-90 degrees
  logic signed [ANG_WIDTH-1:0] m, r17;
  logic                        neg;
  logic signed [CW:0]          xe, ye;
  logic signed [CW:0]          x1_r, y1_r, x1_nxt, y1_nxt;
  z_t                          z1_r, z1_nxt;

  // stage 2: inverse gain
  logic signed [GUARD_BITS:0] kk;
  logic signed [W-1:0]        x2_r, y2_r;
  z_t                         z2_r;

  assign rdy2  = !v2_r || rdy_i;
  assign rdy1  = !v1_r || rdy2;
  assign rdy0  = !v0_r || rdy1;
  assign rdy_o = rdy0;

  always_comb begin
    a18 = {a_i[ANG_WIDTH-1], a_i};
    m1  = (a18 < 0) ? a18 + (ANG_WIDTH+1)'(FULL_TURN) : a18;
    if (m1 < 0) begin
      m2 = m1 + (ANG_WIDTH+1)'(FULL_TURN);
    end else if (m1 >= (ANG_WIDTH+1)'(FULL_TURN)) begin
      m2 = m1 - (ANG_WIDTH+1)'(FULL_TURN);
    end else begin
      m2 = m1;
    end
  end

  always_comb begin
    m   = {1'b0, m_r};
    neg = (m > ANG_WIDTH'(QUARTER_TURN)) && (m < ANG_WIDTH'(FULL_TURN - QUARTER_TURN));
    if (neg) begin
      r17 = m - ANG_WIDTH'(HALF_TURN);
    end else if (m > ANG_WIDTH'(QUARTER_TURN)) begin
      r17 = m - ANG_WIDTH'(FULL_TURN);
    end else begin
      r17 = m;
    end
    xe     = {x0_r[CW-1], x0_r};
    ye     = {y0_r[CW-1], y0_r};
    x1_nxt = neg ? -xe : xe;
    y1_nxt = neg ? -ye : ye;
    z1_nxt = z_t'(r17) <<< ANG_SHIFT;
  end

  assign kk = {1'b0, INV_GAIN_Q30};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= v_i;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v_i && rdy0) begin
      m_r  <= m2[ANG_WIDTH-2:0];
      x0_r <= x_i;
      y0_r <= y_i;
    end
    if (v0_r && rdy1) begin
      x1_r <= x1_nxt;
      y1_r <= y1_nxt;
      z1_r <= z1_nxt;
    end
    if (v1_r && rdy2) begin
      x2_r <= W'(x1_r) * W'(kk);
      y2_r <= W'(y1_r) * W'(kk);
      z2_r <= z1_r;
    end
  end

  assign v_o = v2_r;
  assign x_o = x2_r;
  assign y_o = y2_r;
  assign z_o = z2_r;

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (z1_r <= z_t'(QUARTER_TURN * 512) && z1_r >= -z_t'(QUARTER_TURN * 512)))
    else $error("folded angle outside quarter turn");

endmodule

### sv/prb_iter.sv
// One micro-rotation stage of the rotator with its pipeline register.
// Shift amount and arctangent fixed by IDX. Depends on prb_pkg.
module prb_iter #(
  parameter int CW  = 16,
  parameter int IDX = 0
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   v_i,
  output logic                                   rdy_o,
  input  logic signed [CW+prb_pkg::EXT_BITS-1:0] x_i,
  input  logic signed [CW+prb_pkg::EXT_BITS-1:0] y_i,
  input  prb_pkg::z_t                            z_i,
  output logic                                   v_o,
  input  logic                                   rdy_i,
  output logic signed [CW+prb_pkg::EXT_BITS-1:0] x_o,
  output logic signed [CW+prb_pkg::EXT_BITS-1:0] y_o,
  output prb_pkg::z_t                            z_o
);
  import prb_pkg::*;

  localparam int W = CW + EXT_BITS;

  logic                v_r;
  logic signed [W-1:0] dx, dy, x_r, y_r, x_nxt, y_nxt;
  z_t                  z_r, z_nxt;

  assign rdy_o = !v_r || rdy_i;
  assign dx    = y_i >>> IDX;
  assign dy    = x_i >>> IDX;

  always_comb begin
    if (z_i >= 0) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i - ATAN_TBL[IDX];
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i + ATAN_TBL[IDX];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (v_i && rdy_o) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign v_o = v_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

### sv/prb_out.sv
// Output stage: round half up, clamp to the coordinate range, output register.
// Depends on prb_pkg.
module prb_out #(
  parameter int CW = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   v_i,
  output logic                                   rdy_o,
  input  logic signed [CW+prb_pkg::EXT_BITS-1:0] x_i,
  input  logic signed [CW+prb_pkg::EXT_BITS-1:0] y_i,
  output logic                                   v_o,
  input  logic                                   rdy_i,
  output logic signed [CW-1:0]                   x_o,
  output logic signed [CW-1:0]                   y_o,
  output logic                                   sat_o
);
  import prb_pkg::*;

  localparam int W = CW + EXT_BITS;
  localparam int Q = W - GUARD_BITS;
  localparam logic signed [W-1:0] RND = W'(1) <<< (GUARD_BITS - 1);
  localparam logic signed [Q-1:0] HI  = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [Q-1:0] LO  = {3'b111, {(CW-1){1'b0}}};

  logic                 v_r, sat_r, sat_nxt, cx, cy;
  logic signed [W-1:0]  sx, sy;
  logic signed [Q-1:0]  qx, qy;
  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt;

  assign rdy_o = !v_r || rdy_i;

  always_comb begin
    sx = x_i + RND;
    sy = y_i + RND;
    qx = sx[W-1:GUARD_BITS];
    qy = sy[W-1:GUARD_BITS];
    cx = (qx > HI) || (qx < LO);
    cy = (qy > HI) || (qy < LO);
    if (qx > HI)      x_nxt = HI[CW-1:0];
    else if (qx < LO) x_nxt = LO[CW-1:0];
    else              x_nxt = qx[CW-1:0];
    if (qy > HI)      y_nxt = HI[CW-1:0];
    else if (qy < LO) y_nxt = LO[CW-1:0];
    else              y_nxt = qy[CW-1:0];
    sat_nxt = cx || cy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy_o) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (v_i && rdy_o) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign v_o   = v_r;
  assign x_o   = x_r;
  assign y_o   = y_r;
  assign sat_o = sat_r;

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && sat_r) |-> (x_r == HI[CW-1:0] || x_r == LO[CW-1:0] ||
                        y_r == HI[CW-1:0] || y_r == LO[CW-1:0]))
    else $error("saturated flag without a clamped coordinate");

endmodule
